// ===== src/lidar_angle_aperture_filter_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the lidar angle aperture filter
// Concurrent checks on the clock with a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef LIDAR_ANGLE_APERTURE_FILTER_ASSERT_SVH
`define LIDAR_ANGLE_APERTURE_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define LAAF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LAAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LAAF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LAAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/laaf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// laaf_pkg
// Shared widths, codes, types and the angle wrap function of the filter.
// ---------------------------------------------------------------------------
package laaf_pkg;

  localparam int ANGLE_W    = 16;  // raw return angle, 1/64 degree
  localparam int BOUND_W    = 15;  // wrapped angle / sector bound
  localparam int HALF_W     = 14;  // opening half angle
  localparam int CNT_W      = 2;   // sector count
  localparam int VERDICT_W  = 2;
  localparam int HIT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int WRAP_W     = 18;
  localparam int MAX_SECTORS = 3;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [BOUND_W-1:0] bound_t;
  typedef logic        [HALF_W-1:0]  half_t;
  typedef logic        [CNT_W-1:0]   count_t;
  typedef logic        [VERDICT_W-1:0] verdict_t;
  typedef logic        [HIT_W-1:0]   hit_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

  // Half and full turn in 1/64 degree
  localparam logic signed [WRAP_W-1:0] WRAP_HALF = 18'sd11520;
  localparam logic signed [WRAP_W-1:0] WRAP_FULL = 18'sd23040;
  localparam half_t  HALF_TURN = 14'd11520;
  localparam bound_t BOUND_MIN = -15'sd11520;
  localparam bound_t BOUND_MAX = 15'sd11519;

  // Register indexes; sector k start sits at SECTOR_BASE + 2k, its end one above
  localparam cfg_idx_t REG_HALF_ANGLE   = 3'd0;
  localparam cfg_idx_t REG_SECTOR_COUNT = 3'd1;
  localparam int       REG_SECTOR_BASE  = 2;

  // Verdict codes
  localparam verdict_t VERDICT_ACCEPT  = 2'd0;
  localparam verdict_t VERDICT_OUTSIDE = 2'd1;
  localparam verdict_t VERDICT_MASKED  = 2'd2;

  // Fold any angle of the input span into [-180, +180) degrees. One compare
  // and correction suffices: the input never lies more than one turn out.
  function automatic bound_t wrap_angle(input logic signed [ANGLE_W:0] a);
    logic signed [WRAP_W-1:0] x;
    x = WRAP_W'(a);
    if (x >= WRAP_HALF) begin
      x = x - WRAP_FULL;
    end else if (x < -WRAP_HALF) begin
      x = x + WRAP_FULL;
    end
    return x[BOUND_W-1:0];
  endfunction

endpackage

// ===== src/laaf_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// laaf_in_if
// Input channel: one return angle per word.
// ---------------------------------------------------------------------------
interface laaf_in_if;
  import laaf_pkg::*;

  logic   valid;
  logic   ready;
  angle_t angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

// ===== src/laaf_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// laaf_out_if
// Result channel: verdict code and matching sector per word.
// ---------------------------------------------------------------------------
interface laaf_out_if;
  import laaf_pkg::*;

  logic     valid;
  logic     ready;
  verdict_t verdict;
  hit_t     sector_hit;

  modport source (output valid, output verdict, output sector_hit, input ready);
  modport sink   (input valid, input verdict, input sector_hit, output ready);
endinterface

// ===== src/lidar_angle_aperture_filter.sv =====
`timescale 1ns / 1ps
`include "lidar_angle_aperture_filter_assert.svh"
// ---------------------------------------------------------------------------
// lidar_angle_aperture_filter
// Classifies lidar return angles against an opening and masked sectors.
// ---------------------------------------------------------------------------
//
//  channel  | direction | word
//  ---------+-----------+------------------------------------------------
//  in_ch    | sink      | angle (signed 16 bit, 1/64 degree)
//  out_ch   | source    | verdict (2 bit), sector_hit (2 bit)
//  cfg_*    | write     | cfg_index selects register, cfg_data 15 bit
//
//  One word per cycle sustained while out_ch takes results. An accepted word
//  is held in the input register, then moves into the result register and
//  is offered on out_ch from there.
//  The classifier between the two is a wrap, an absolute value and three
//  pairs of compares.
//  rst_n (synchronous) empties both stages and loads the register reset values.
//  A stall on out_ch holds the result; the input register still takes one more
//  word, after which in_ch.ready drops until the result is taken.
//
module lidar_angle_aperture_filter #(
  parameter int NUM_SECTORS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  laaf_in_if.sink             in_ch,
  laaf_out_if.source          out_ch,
  input  logic                cfg_we,
  input  laaf_pkg::cfg_idx_t  cfg_index,
  input  laaf_pkg::cfg_data_t cfg_data
);
  import laaf_pkg::*;

  half_t    half_angle;
  count_t   sector_count;
  bound_t   sector_start [NUM_SECTORS];
  bound_t   sector_stop  [NUM_SECTORS];

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  angle_t   angle_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  verdict_t verdict_r;
  hit_t     hit_r;
  verdict_t verdict_nxt;
  hit_t     hit_nxt;

  logic     out_free;
  logic     s1_adv;
  logic     in_acc;

  laaf_cfg_regs #(
    .NUM_SECTORS (NUM_SECTORS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .half_angle   (half_angle),
    .sector_count (sector_count),
    .sector_start (sector_start),
    .sector_stop  (sector_stop)
  );

  laaf_classify #(
    .NUM_SECTORS (NUM_SECTORS)
  ) u_classify (
    .angle        (angle_r),
    .half_angle   (half_angle),
    .sector_count (sector_count),
    .sector_start (sector_start),
    .sector_stop  (sector_stop),
    .verdict      (verdict_nxt),
    .sector_hit   (hit_nxt)
  );

  // Result slot is free when empty or being taken this cycle
  assign out_free    = !out_valid_r || out_ch.ready;
  // Advance the input register into the result register
  assign s1_adv      = s1_valid_r && out_free;
  // Take a new word whenever the input register empties or moves on
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold unless a new word moves in
  always_ff @(posedge clk) begin
    if (in_acc) begin
      angle_r <= in_ch.angle;
    end
    if (s1_adv) begin
      verdict_r <= verdict_nxt;
      hit_r     <= hit_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.verdict    = verdict_r;
  assign out_ch.sector_hit = hit_r;

  `LAAF_ASSERT_NEXT(a_s1_fill, clk, rst_n, in_acc, s1_valid_r, "accepted word missing from input register")
  `LAAF_ASSERT_NEXT(a_s1_hold, clk, rst_n, (s1_valid_r && !out_free), (s1_valid_r && $stable(angle_r)), "input register changed while blocked")
  `LAAF_ASSERT_NEXT(a_out_load, clk, rst_n, s1_adv, out_valid_r, "advanced word missing from result register")
  `LAAF_ASSERT_IMPL(a_hit_zero, clk, rst_n, (out_valid_r && verdict_r != VERDICT_MASKED), (hit_r == '0), "sector index set without masked verdict")
  `LAAF_ASSERT_IMPL(a_verdict_code, clk, rst_n, out_valid_r, (verdict_r == VERDICT_ACCEPT || verdict_r == VERDICT_OUTSIDE || verdict_r == VERDICT_MASKED), "undefined verdict code")

endmodule

// ===== src/laaf_cfg_regs.sv =====
`timescale 1ns / 1ps
`include "lidar_angle_aperture_filter_assert.svh"
// ---------------------------------------------------------------------------
// laaf_cfg_regs
// Configuration register file; sector bounds are stored already wrapped.
// ---------------------------------------------------------------------------
module laaf_cfg_regs #(
  parameter int NUM_SECTORS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  laaf_pkg::cfg_idx_t  cfg_index,
  input  laaf_pkg::cfg_data_t cfg_data,
  output laaf_pkg::half_t     half_angle,
  output laaf_pkg::count_t    sector_count,
  output laaf_pkg::bound_t    sector_start [NUM_SECTORS],
  output laaf_pkg::bound_t    sector_stop  [NUM_SECTORS]
);
  import laaf_pkg::*;

  half_t  half_angle_r;
  count_t sector_count_r;
  bound_t wrapped_data;

  // Wrap the written bound once here so the data path sees only folded values
  assign wrapped_data = wrap_angle((ANGLE_W+1)'(signed'(cfg_data)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_angle_r   <= HALF_TURN;
      sector_count_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_HALF_ANGLE) begin
        half_angle_r <= cfg_data[HALF_W-1:0];
      end
      if (cfg_index == REG_SECTOR_COUNT) begin
        sector_count_r <= cfg_data[CNT_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < NUM_SECTORS; k++) begin : g_sector
    localparam cfg_idx_t START_IDX = CFG_IDX_W'(REG_SECTOR_BASE + 2 * k);
    localparam cfg_idx_t STOP_IDX  = CFG_IDX_W'(REG_SECTOR_BASE + 2 * k + 1);

    bound_t start_r;
    bound_t stop_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        start_r <= '0;
        stop_r  <= '0;
      end else if (cfg_we) begin
        if (cfg_index == START_IDX) begin
          start_r <= wrapped_data;
        end
        if (cfg_index == STOP_IDX) begin
          stop_r <= wrapped_data;
        end
      end
    end

    assign sector_start[k] = start_r;
    assign sector_stop[k]  = stop_r;

    `LAAF_ASSERT_IMPL(a_start_range, clk, rst_n, 1'b1, (start_r >= BOUND_MIN && start_r <= BOUND_MAX), "sector start left the wrapped range")
    `LAAF_ASSERT_IMPL(a_stop_range, clk, rst_n, 1'b1, (stop_r >= BOUND_MIN && stop_r <= BOUND_MAX), "sector end left the wrapped range")
  end

  assign half_angle   = half_angle_r;
  assign sector_count = sector_count_r;

  `LAAF_ASSERT_NEXT(a_count_write, clk, rst_n, (cfg_we && cfg_index == REG_SECTOR_COUNT), (sector_count_r == $past(cfg_data[CNT_W-1:0])), "sector count write lost")

endmodule

// ===== src/laaf_classify.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// laaf_classify
// Wrap one angle, test the opening, then the sectors in use, lowest first.
// ---------------------------------------------------------------------------
module laaf_classify #(
  parameter int NUM_SECTORS = 3
) (
  input  laaf_pkg::angle_t   angle,
  input  laaf_pkg::half_t    half_angle,
  input  laaf_pkg::count_t   sector_count,
  input  laaf_pkg::bound_t   sector_start [NUM_SECTORS],
  input  laaf_pkg::bound_t   sector_stop  [NUM_SECTORS],
  output laaf_pkg::verdict_t verdict,
  output laaf_pkg::hit_t     sector_hit
);
  import laaf_pkg::*;

  bound_t a;
  bound_t neg_a;
  half_t  mag;
  logic   outside;
  logic   masked;
  hit_t   hit;

  assign a       = wrap_angle((ANGLE_W+1)'(angle));
  assign neg_a   = -a;
  assign mag     = a[BOUND_W-1] ? neg_a[HALF_W-1:0] : a[HALF_W-1:0];
  assign outside = mag > half_angle;

  // Scan from the top so the lowest matching sector wins
  always_comb begin
    logic in_sec;
    masked = 1'b0;
    hit    = '0;
    for (int k = NUM_SECTORS - 1; k >= 0; k--) begin
      if (sector_start[k] <= sector_stop[k]) begin
        in_sec = (a >= sector_start[k]) && (a <= sector_stop[k]);
      end else begin
        in_sec = (a >= sector_start[k]) || (a <= sector_stop[k]);
      end
      if (in_sec && (k < int'(sector_count))) begin
        masked = 1'b1;
        hit    = HIT_W'(k);
      end
    end
  end

  always_comb begin
    if (outside) begin
      verdict    = VERDICT_OUTSIDE;
      sector_hit = '0;
    end else if (masked) begin
      verdict    = VERDICT_MASKED;
      sector_hit = hit;
    end else begin
      verdict    = VERDICT_ACCEPT;
      sector_hit = '0;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar angle aperture filter. It streams angle
// words through the valid/ready channels under a series of opening and
// sector settings. It idles both channels at random and holds the result
// channel off for a long stretch. It predicts each verdict and compares the
// results in order.
// ---------------------------------------------------------------------------
module tb_top;
  import laaf_pkg::*;

  localparam int NUM_SECTORS   = 3;
  localparam int TURN_HALF     = 11520;
  localparam int TURN_FULL     = 23040;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_WORDS   = 140;
  localparam int PRESSURE_WORDS = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    verdict_t verdict;
    hit_t     sector_hit;
  } result_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  laaf_in_if  in_ch ();
  laaf_out_if out_ch ();

  lidar_angle_aperture_filter #(
    .NUM_SECTORS(NUM_SECTORS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Filter settings as the block should hold them after each write
  half_t  open_half;
  count_t mask_count;
  bound_t mask_lo [MAX_SECTORS];
  bound_t mask_hi [MAX_SECTORS];

  angle_t  angle_backlog [$];   // angle words still to be offered
  result_t verdict_queue [$];   // verdicts owed for accepted words, oldest first

  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  logic stall_hold;
  logic hold_go;
  int   mismatches    = 0;
  int   cycle_count   = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Fold any angle into [-180, +180) degrees, 1/64 degree units
  function automatic int fold_angle(input int a);
    int f;
    f = (a + TURN_HALF) % TURN_FULL;
    if (f < 0) begin
      f = f + TURN_FULL;
    end
    return f - TURN_HALF;
  endfunction

  // Opening check first, then the sectors in use in index order; first hit wins
  function automatic result_t classify_angle(input angle_t raw);
    int      a;
    int      mag;
    int      used;
    int      k;
    int      s;
    int      e;
    bit      found;
    result_t r;
    r.verdict    = VERDICT_ACCEPT;
    r.sector_hit = '0;
    found        = 1'b0;
    a    = fold_angle(int'(raw));
    mag  = (a < 0) ? -a : a;
    used = (int'(mask_count) < NUM_SECTORS) ? int'(mask_count) : NUM_SECTORS;
    if (mag > int'(open_half)) begin
      r.verdict = VERDICT_OUTSIDE;
    end else begin
      for (k = 0; k < used; k++) begin
        s = fold_angle(int'(mask_lo[k]));
        e = fold_angle(int'(mask_hi[k]));
        // a start above the end wraps the sector through +-180
        if (!found && ((s <= e) ? (a >= s && a <= e) : (a >= s || a <= e))) begin
          found        = 1'b1;
          r.verdict    = VERDICT_MASKED;
          r.sector_hit = hit_t'(k);
        end
      end
    end
    return r;
  endfunction

  // Driver: predict on every accepted word, then offer the next or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        verdict_queue.insert(verdict_queue.size(), classify_angle(in_ch.angle));
      end
      // hold the word until it is taken
      if (!in_ch.valid || in_ch.ready) begin
        if (angle_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.angle <= angle_backlog.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result word with the oldest verdict owed
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected result word: verdict %0d sector %0d",
                     out_ch.verdict, out_ch.sector_hit);
          end
        end else begin
          want = verdict_queue.pop_front();
          if (out_ch.verdict !== want.verdict || out_ch.sector_hit !== want.sector_hit) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("result word: expected verdict %0d sector %0d, got verdict %0d sector %0d",
                       want.verdict, want.sector_hit, out_ch.verdict, out_ch.sector_hit);
            end
          end
        end
      end
      out_ch.ready <= !stall_hold && ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Long receiver hold-off, timed here once the stimulus asks for it
  initial begin : stall_timer
    stall_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    stall_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_hold <= 1'b0;
  end

  // Watchdog: abandon a run that stops making progress
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lidar_angle_aperture_filter: mismatch");
      $finish;
    end
  end

  // Write one register at the next edge and track it. Call on a rising edge.
  task automatic load_reg(input cfg_idx_t idx, input cfg_data_t val);
    int k;
    if (idx == REG_HALF_ANGLE) begin
      open_half = val[HALF_W-1:0];
    end else if (idx == REG_SECTOR_COUNT) begin
      mask_count = val[CNT_W-1:0];
    end else begin
      k = (int'(idx) - REG_SECTOR_BASE) / 2;
      // even index is a sector start, odd its end
      if (idx[0] == 1'b0) begin
        mask_lo[k] = bound_t'(val);
      end else begin
        mask_hi[k] = bound_t'(val);
      end
    end
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_filter(input int half_word, input int count_word,
                                input int lo0, input int hi0, input int lo1,
                                input int hi1, input int lo2, input int hi2);
    load_reg(REG_HALF_ANGLE, cfg_data_t'(half_word));
    load_reg(REG_SECTOR_COUNT, cfg_data_t'(count_word));
    load_reg(cfg_idx_t'(REG_SECTOR_BASE + 0), cfg_data_t'(lo0));
    load_reg(cfg_idx_t'(REG_SECTOR_BASE + 1), cfg_data_t'(hi0));
    load_reg(cfg_idx_t'(REG_SECTOR_BASE + 2), cfg_data_t'(lo1));
    load_reg(cfg_idx_t'(REG_SECTOR_BASE + 3), cfg_data_t'(hi1));
    load_reg(cfg_idx_t'(REG_SECTOR_BASE + 4), cfg_data_t'(lo2));
    load_reg(cfg_idx_t'(REG_SECTOR_BASE + 5), cfg_data_t'(hi2));
    cfg_we <= 1'b0;
  endtask

  // Sector bound: mostly in range, some extremes, some raw words that fold
  function automatic int pick_bound();
    case ($urandom_range(0, 7))
      0:       return -TURN_HALF;
      1:       return TURN_HALF - 1;
      2:       return int'($urandom_range(0, 32767)) - 16384;
      default: return int'($urandom_range(0, TURN_FULL - 1)) - TURN_HALF;
    endcase
  endfunction

  task automatic random_setup();
    int half_word;
    int count_word;
    int k;
    int lo [MAX_SECTORS];
    int hi [MAX_SECTORS];
    case ($urandom_range(0, 5))
      0:       half_word = 0;
      1:       half_word = TURN_HALF;
      2:       half_word = 16383;
      3:       half_word = TURN_HALF - 1;
      4:       half_word = int'($urandom_range(0, 16383));
      default: half_word = int'($urandom_range(1, TURN_HALF));
    endcase
    // spare upper bits of the data word ride along and must be dropped
    half_word  = half_word + (int'($urandom_range(0, 1)) << HALF_W);
    count_word = int'($urandom_range(0, 3)) + (int'($urandom_range(0, 8191)) << CNT_W);
    for (k = 0; k < MAX_SECTORS; k++) begin
      lo[k] = pick_bound();
      case ($urandom_range(0, 3))
        0, 1: begin
          hi[k] = lo[k] + int'($urandom_range(0, 3000));
          if (hi[k] > TURN_HALF - 1) begin
            hi[k] = hi[k] - TURN_FULL;
          end
        end
        2:       hi[k] = pick_bound();
        default: hi[k] = lo[k];
      endcase
    end
    program_filter(half_word, count_word, lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
  endtask

  // Angle word: four in ten anywhere, three in ten in one turn, the rest near an edge
  function automatic angle_t pick_angle();
    int t;
    int off;
    int sel;
    int k;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return angle_t'($urandom);
    end
    if (sel < 7) begin
      return angle_t'(int'($urandom_range(0, TURN_FULL - 1)) - TURN_HALF);
    end
    sel = $urandom_range(0, 9);
    case (sel)
      0:       t = int'(open_half);
      1:       t = -int'(open_half);
      2:       t = TURN_HALF - 1;
      3:       t = -TURN_HALF;
      default: begin
        k = (sel - 4) / 2;
        t = (sel[0] == 1'b0) ? fold_angle(int'(mask_lo[k])) : fold_angle(int'(mask_hi[k]));
      end
    endcase
    t   = t + int'($urandom_range(0, 4)) - 2;
    off = (int'($urandom_range(0, 2)) - 1) * TURN_FULL;
    // step a whole turn away where the word still holds it
    if (t + off >= -32768 && t + off <= 32767) begin
      t = t + off;
    end
    return angle_t'(t);
  endfunction

  task automatic queue_angle(input int a);
    angle_backlog.insert(angle_backlog.size(), angle_t'(a));
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        src_idle_pct  <= 69;
        snk_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        src_idle_pct  <= 0;
        snk_stall_pct <= 69;
      end
      IDLE_BOTH: begin
        src_idle_pct  <= 15;
        snk_stall_pct <= 15;
      end
      default: begin
        src_idle_pct  <= 0;
        snk_stall_pct <= 0;
      end
    endcase
  endtask

  // Wait until every word is offered, taken and checked; sample away from
  // the rising edge, then realign to it.
  task automatic drain_filter();
    do begin
      @(negedge clk);
    end while (angle_backlog.size() != 0 || in_ch.valid || verdict_queue.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    int p;
    int k;
    rst_n        = 1'b0;
    hold_go      = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    open_half    = HALF_TURN;
    mask_count   = '0;
    for (k = 0; k < MAX_SECTORS; k++) begin
      mask_lo[k] = '0;
      mask_hi[k] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: unrestricted opening, no sectors; extreme words fold
    set_idle(IDLE_NONE);
    queue_angle(-32768);
    queue_angle(32767);
    queue_angle(TURN_HALF);
    drain_filter();

    // Overlapping sectors (first match wins) and one wrapping through +-180
    program_filter(TURN_HALF, 3, -1000, 1000, 10000, -10000, 500, 2000);
    queue_angle(0);
    queue_angle(1000);
    queue_angle(1001);
    queue_angle(2001);
    queue_angle(TURN_HALF - 1);
    queue_angle(-TURN_HALF);
    queue_angle(10000);
    queue_angle(9999);
    queue_angle(-10001);
    queue_angle(TURN_FULL + 500);
    drain_filter();

    // Narrow opening with its edges; sector 0 bounds given as raw words that
    // fold; two sectors in use, so sector 2 is never tested
    program_filter(4608, 2, 12000, 12500, 0, 100, -4700, -4000);
    queue_angle(4608);
    queue_angle(4609);
    queue_angle(-4608);
    queue_angle(-4609);
    queue_angle(50);
    queue_angle(-4200);
    drain_filter();

    // Closed opening: only a zero angle gets in
    program_filter(0, 0, 0, 0, 0, 0, 0, 0);
    queue_angle(0);
    queue_angle(1);
    queue_angle(-1);
    queue_angle(TURN_FULL);
    drain_filter();

    // Widest half angle word; a sector covering only the two ends of the turn
    program_filter(32767, 1, TURN_HALF - 1, -TURN_HALF, 0, 0, 0, 0);
    queue_angle(TURN_HALF - 1);
    queue_angle(-TURN_HALF);
    drain_filter();

    // Random settings, each under its own idling pattern
    for (p = 0; p < RANDOM_PHASES; p++) begin
      random_setup();
      set_idle(idle_mode_t'(p % 4));
      repeat (PHASE_WORDS) queue_angle(int'(pick_angle()));
      drain_filter();
    end

    // Hold the result channel off while words keep coming, to back the
    // block up until it stalls its input
    random_setup();
    set_idle(IDLE_NONE);
    hold_go <= 1'b1;
    repeat (PRESSURE_WORDS) queue_angle(int'(pick_angle()));
    wait (stall_hold);
    wait (!stall_hold);
    drain_filter();

    repeat (4) @(posedge clk);
    if (mismatches == 0 && verdict_queue.size() == 0) begin
      $display("lidar_angle_aperture_filter: match");
    end else begin
      $display("lidar_angle_aperture_filter: mismatch");
    end
    $finish;
  end

endmodule
